@@ hdl/dos_pkg.sv @@
// package for the door opener sequencer: payload types, codes and register defaults
// no dependencies; used by the interfaces and the top level
package dos_pkg;

	localparam int TIMER_BITS = 16;
	localparam int REG_BITS   = 16;
	localparam int CMP_W      = (TIMER_BITS > REG_BITS) ? TIMER_BITS : REG_BITS;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [1:0] REG_MODE    = 2'd0;
	localparam logic [1:0] REG_HOLD    = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;

	localparam logic [1:0] MODE_AUTO   = 2'd0;
	localparam logic [1:0] MODE_MANUAL = 2'd1;

	localparam logic [2:0] POS_OPEN   = 3'd1;
	localparam logic [2:0] POS_CLOSED = 3'd2;

	localparam logic [1:0]          MODE_RESET    = MODE_AUTO;
	localparam logic [REG_BITS-1:0] HOLD_RESET    = 16'd3000;
	localparam logic [REG_BITS-1:0] TIMEOUT_RESET = 16'd5000;

	typedef struct packed {
		logic [2:0] door_position;
		logic       inside_radar;
		logic       outside_radar;
		logic       inside_presence;
		logic       outside_presence;
		logic       switch_inside;
		logic       switch_outside;
		logic       lock_engaged;
	} door_item_t;

	typedef struct packed {
		logic [2:0] controller_state;
		logic       opener_request;
		logic       change_pending;
	} door_result_t;

endpackage

@@ hdl/dos_ifs.sv @@
// valid/ready channel interfaces for tick items and result items
// depends on dos_pkg
interface dos_item_if;
	logic                valid;
	logic                ready;
	dos_pkg::door_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dos_result_if;
	logic                  valid;
	logic                  ready;
	dos_pkg::door_result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hdl/door_opener_sequencer.sv @@
// door opener sequencer top level: input register, controller step, result register
// depends on dos_pkg and dos_ifs
//
// One tick item is taken per clock cycle while results are taken. An accepted
// item sits in the input register; once the result register is empty or being
// taken, the controller step (position tracking, saturating counters, six-state
// controller) is evaluated and written to the result register together with the
// state update. A result thus passes the input register and then the result
// register before it is presented. A result that waits holds the controller
// step; the input register then fills and the input stalls. Input ready follows
// result ready combinationally. The user must write registers over the APB port
// only while no tick is in flight; the block itself does not enforce this.
module door_opener_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	dos_item_if.sink                        item_in,
	dos_result_if.source                    result_out,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dos_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [dos_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [dos_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import dos_pkg::*;

	typedef enum logic [2:0] {
		ST_UNDEF      = 3'd0,
		ST_OPEN_START = 3'd1,
		ST_OPEN       = 3'd2,
		ST_CLOSED     = 3'd3,
		ST_LOCKED     = 3'd4,
		ST_TRANS      = 3'd5
	} ctrl_state_t;

	localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

	// configuration registers
	logic [1:0]          mode_q;
	logic [REG_BITS-1:0] hold_q;
	logic [REG_BITS-1:0] timeout_q;
	logic                cfg_wr;
	logic [1:0]          cfg_idx;

	// input stage
	logic       valid_s1;
	door_item_t item_s1;

	// controller state
	ctrl_state_t           ctrl_q, ctrl_d;
	logic [2:0]            prev_pos_q;
	logic                  flag_q, flag_d;
	logic [TIMER_BITS-1:0] since_change_q, since_change_d;
	logic [TIMER_BITS-1:0] since_open_q, since_open_d;

	// result stage
	logic         out_valid_q;
	door_result_t out_q;

	logic in_xfer, adv;
	logic request;

	logic [2:0]            pos;
	logic                  changed, autom, sw, trig;
	logic [TIMER_BITS-1:0] sc_inc, so_inc;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (cfg_idx)
			REG_MODE:    prdata = APB_DATA_W'(mode_q);
			REG_HOLD:    prdata = APB_DATA_W'(hold_q);
			REG_TIMEOUT: prdata = APB_DATA_W'(timeout_q);
			default:     prdata = '0;
		endcase
	end

	assign adv           = valid_s1 && (!out_valid_q || result_out.ready);
	assign item_in.ready = !valid_s1 || adv;
	assign in_xfer       = item_in.valid && item_in.ready;

	assign result_out.valid = out_valid_q;
	assign result_out.data  = out_q;

	// controller step on the registered item
	always_comb begin
		pos     = item_s1.door_position;
		sw      = item_s1.switch_inside || item_s1.switch_outside;
		autom   = (mode_q == MODE_AUTO);
		sc_inc  = (since_change_q == TIMER_MAX) ? since_change_q : since_change_q + 1'b1;
		so_inc  = (since_open_q == TIMER_MAX) ? since_open_q : since_open_q + 1'b1;
		changed = (pos != prev_pos_q);

		since_change_d = changed ? '0 : sc_inc;
		since_open_d   = so_inc;
		flag_d         = flag_q || changed;
		ctrl_d         = ctrl_q;
		request        = 1'b0;
		trig           = 1'b0;

		if (mode_q == MODE_AUTO || mode_q == MODE_MANUAL) begin
			case (ctrl_q)
				ST_UNDEF: begin
					if (pos == POS_OPEN)
						ctrl_d = ST_OPEN_START;
					else if (pos == POS_CLOSED)
						ctrl_d = ST_CLOSED;
				end
				ST_OPEN_START: begin
					since_open_d = '0;
					ctrl_d       = ST_OPEN;
				end
				ST_OPEN: begin
					if (pos != POS_OPEN) begin
						ctrl_d = ST_UNDEF;
					end else begin
						if (autom)
							trig = !item_s1.inside_radar && !item_s1.outside_radar &&
								!item_s1.inside_presence && !item_s1.outside_presence &&
								(CMP_W'(so_inc) >= CMP_W'(hold_q));
						else
							trig = !item_s1.inside_presence && !item_s1.outside_presence && sw;
						if (trig) begin
							request = 1'b1;
							ctrl_d  = ST_TRANS;
						end
					end
				end
				ST_CLOSED: begin
					if (pos != POS_CLOSED) begin
						ctrl_d = ST_UNDEF;
					end else if (item_s1.lock_engaged) begin
						ctrl_d = ST_LOCKED;
					end else begin
						trig = autom ? (item_s1.inside_radar || item_s1.outside_radar) : sw;
						if (trig) begin
							request = 1'b1;
							ctrl_d  = ST_TRANS;
						end
					end
				end
				ST_LOCKED: begin
					if (pos != POS_CLOSED)
						ctrl_d = ST_UNDEF;
					else if (!item_s1.lock_engaged)
						ctrl_d = ST_CLOSED;
				end
				ST_TRANS: begin
					if (flag_d || (CMP_W'(since_change_d) >= CMP_W'(timeout_q))) begin
						if (pos == POS_OPEN)
							ctrl_d = ST_OPEN_START;
						else if (pos == POS_CLOSED)
							ctrl_d = ST_CLOSED;
					end
				end
				default: ctrl_d = ST_UNDEF;
			endcase
			if (request) begin
				flag_d         = 1'b0;
				since_change_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_RESET;
			hold_q         <= HOLD_RESET;
			timeout_q      <= TIMEOUT_RESET;
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
			ctrl_q         <= ST_UNDEF;
			prev_pos_q     <= '0;
			flag_q         <= 1'b0;
			since_change_q <= '0;
			since_open_q   <= '0;
		end else begin
			if (cfg_wr) begin
				case (cfg_idx)
					REG_MODE:    mode_q    <= pwdata[1:0];
					REG_HOLD:    hold_q    <= pwdata[REG_BITS-1:0];
					REG_TIMEOUT: timeout_q <= pwdata[REG_BITS-1:0];
					default: ;
				endcase
			end
			if (in_xfer)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				out_valid_q <= 1'b1;
			else if (result_out.ready)
				out_valid_q <= 1'b0;
			if (adv) begin
				ctrl_q         <= ctrl_d;
				prev_pos_q     <= pos;
				flag_q         <= flag_d;
				since_change_q <= since_change_d;
				since_open_q   <= since_open_d;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer)
			item_s1 <= item_in.data;
		if (adv) begin
			out_q.controller_state <= ctrl_d;
			out_q.opener_request   <= request;
			out_q.change_pending   <= flag_d;
		end
	end

	a_req_enters_trans: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.opener_request |-> out_q.controller_state == ST_TRANS)
		else $error("opener request without transition state");

	a_req_clears_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.opener_request |-> !out_q.change_pending)
		else $error("change pending set on request");

	a_frozen_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv && mode_q[1] |=> $stable(ctrl_q))
		else $error("controller moved in frozen mode");

	a_frozen_no_request: assert property (@(posedge clk) disable iff (!arst_n)
		adv && mode_q[1] |=> !out_q.opener_request)
		else $error("request raised in frozen mode");

endmodule
